[src/tkct_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types for the top-K count tracker.
// No dependencies; imported by top_k_count_tracker.
package tkct_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int FILL_W  = $clog2(ENTRIES + 1);
	localparam int KEEP_W  = 5;
	localparam int KEY_W   = 32;
	localparam int CNT_W   = 64;
	localparam int DATA_W  = KEY_W + CNT_W;

	localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(10);

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_DRAIN  = 1'b1;

	typedef logic [KEY_W-1:0]  tkct_key_t;
	typedef logic [CNT_W-1:0]  tkct_cnt_t;
	typedef logic [IDX_W-1:0]  tkct_idx_t;
	typedef logic [FILL_W-1:0] tkct_fill_t;

endpackage

[src/top_k_count_tracker.sv]
`timescale 1ns / 1ps
// Top level of the top-K count tracker: slot table, shared compare unit and sequencer.
// Depends on tkct_pkg.
//
// Usage: beats on the s_ stream carry either an insert (s_tuser = 0, key and count in
// s_tdata) or a drain request (s_tuser = 1, s_tdata ignored). Inserts give no output.
// A drain sends every kept pair on the m_ stream in descending count order, lowest slot
// first on ties, with m_tlast on the final beat; m_tuser is the found flag. A drain of
// an empty table sends one beat with found = 0 and m_tlast = 1. cfg_we with cfg_wdata
// sets keep_count, which may only change while the block is idle.
// Operation: one shared 64-bit comparator reads one slot per cycle. An insert into a
// table below its limit is written straight into the next free slot; an insert into
// a full table scans for the minimum, then does the conditional write. A drain scans
// the table once per output beat and waits while the receiver stalls. s_tready is
// high only while the sequencer is idle.
// Reset clears the fill count, the output valid and sets keep_count to 10; slot contents
// are not cleared. When m_tready is low the output register holds its beat and the
// drain sequence waits for it to be taken.
module top_k_count_tracker (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [tkct_pkg::DATA_W-1:0] s_tdata,  // key [31:0], count [95:32]
	input  logic                     s_tuser,     // kind
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [tkct_pkg::DATA_W-1:0] m_tdata,  // out_key [31:0], out_count [95:32]
	output logic                     m_tuser,     // found
	output logic                     m_tlast,     // last
	input  logic                     cfg_we,
	input  logic [tkct_pkg::KEEP_W-1:0] cfg_wdata // keep_count
);
	import tkct_pkg::*;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_INS_SCAN = 3'd1;
	localparam logic [2:0] ST_INS_WR   = 3'd2;
	localparam logic [2:0] ST_DRN_SCAN = 3'd3;
	localparam logic [2:0] ST_DRN_EMIT = 3'd4;

	tkct_key_t key_store_q [ENTRIES];
	tkct_cnt_t cnt_store_q [ENTRIES];

	logic [2:0]        state_q;
	logic [KEEP_W-1:0] keep_q;
	tkct_fill_t        fill_q;
	tkct_fill_t        sent_q;
	tkct_idx_t         idx_q;
	tkct_idx_t         best_idx_q;
	logic              have_q;
	logic [ENTRIES-1:0] done_q;
	tkct_cnt_t         best_cnt_q;
	tkct_key_t         best_key_q;
	tkct_key_t         in_key_q;
	tkct_cnt_t         in_cnt_q;

	logic              out_valid_q;
	tkct_key_t         out_key_q;
	tkct_cnt_t         out_cnt_q;
	logic              out_found_q;
	logic              out_last_q;

	tkct_fill_t limit;
	tkct_key_t  rd_key;
	tkct_cnt_t  rd_cnt;
	tkct_cnt_t  cmp_a;
	tkct_cnt_t  cmp_b;
	logic       cmp_lt;
	logic       scan_end;
	logic       in_fire;
	logic       out_free;
	logic       take_min;
	logic       take_max;
	logic       emit;
	logic       emit_last;
	logic       wr_en;
	tkct_idx_t  wr_idx;
	tkct_key_t  wr_key;
	tkct_cnt_t  wr_cnt;

	always_comb begin
		if (keep_q == '0) begin
			limit = FILL_W'(1);
		end else if (FILL_W'(keep_q) > FILL_W'(ENTRIES)) begin
			limit = FILL_W'(ENTRIES);
		end else begin
			limit = FILL_W'(keep_q);
		end
	end

	// The single comparator is steered by the sequencer state.
	always_comb begin
		case (state_q)
			ST_DRN_SCAN: begin
				cmp_a = best_cnt_q;
				cmp_b = rd_cnt;
			end
			ST_INS_WR: begin
				cmp_a = best_cnt_q;
				cmp_b = in_cnt_q;
			end
			default: begin
				cmp_a = rd_cnt;
				cmp_b = best_cnt_q;
			end
		endcase
	end

	assign cmp_lt    = (cmp_a < cmp_b);
	assign rd_key    = key_store_q[idx_q];
	assign rd_cnt    = cnt_store_q[idx_q];
	assign scan_end  = (FILL_W'(idx_q) == FILL_W'(fill_q - FILL_W'(1)));
	assign s_tready  = (state_q == ST_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign take_min  = !have_q || cmp_lt;
	assign take_max  = !done_q[idx_q] && (!have_q || cmp_lt);
	assign emit      = (state_q == ST_DRN_EMIT) && out_free;
	assign emit_last = (fill_q == '0) || (FILL_W'(sent_q + FILL_W'(1)) == fill_q);

	always_comb begin
		wr_en  = 1'b0;
		wr_idx = fill_q[IDX_W-1:0];
		wr_key = s_tdata[KEY_W-1:0];
		wr_cnt = s_tdata[DATA_W-1:KEY_W];
		case (state_q)
			ST_IDLE: begin
				wr_en = in_fire && (s_tuser == KIND_INSERT) && (fill_q < limit);
			end
			ST_INS_WR: begin
				wr_en  = cmp_lt;
				wr_idx = best_idx_q;
				wr_key = in_key_q;
				wr_cnt = in_cnt_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			keep_q      <= KEEP_RESET;
			fill_q      <= '0;
			sent_q      <= '0;
			idx_q       <= '0;
			have_q      <= 1'b0;
			done_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				keep_q <= cfg_wdata;
			end
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					idx_q  <= '0;
					have_q <= 1'b0;
					sent_q <= '0;
					done_q <= '0;
					if (in_fire) begin
						if (s_tuser == KIND_DRAIN) begin
							state_q <= (fill_q == '0) ? ST_DRN_EMIT : ST_DRN_SCAN;
						end else if (fill_q < limit) begin
							fill_q <= FILL_W'(fill_q + FILL_W'(1));
						end else begin
							state_q <= ST_INS_SCAN;
						end
					end
				end
				ST_INS_SCAN: begin
					have_q <= 1'b1;
					idx_q  <= IDX_W'(idx_q + IDX_W'(1));
					if (scan_end) begin
						state_q <= ST_INS_WR;
					end
				end
				ST_INS_WR: begin
					state_q <= ST_IDLE;
				end
				ST_DRN_SCAN: begin
					if (take_max) begin
						have_q <= 1'b1;
					end
					idx_q <= IDX_W'(idx_q + IDX_W'(1));
					if (scan_end) begin
						state_q <= ST_DRN_EMIT;
					end
				end
				ST_DRN_EMIT: begin
					if (out_free) begin
						idx_q  <= '0;
						have_q <= 1'b0;
						if (emit_last) begin
							fill_q  <= '0;
							state_q <= ST_IDLE;
						end else begin
							done_q[best_idx_q] <= 1'b1;
							sent_q  <= FILL_W'(sent_q + FILL_W'(1));
							state_q <= ST_DRN_SCAN;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_store_q[wr_idx] <= wr_key;
			cnt_store_q[wr_idx] <= wr_cnt;
		end
		if (in_fire) begin
			in_key_q <= s_tdata[KEY_W-1:0];
			in_cnt_q <= s_tdata[DATA_W-1:KEY_W];
		end
		if (((state_q == ST_INS_SCAN) && take_min) ||
		    ((state_q == ST_DRN_SCAN) && take_max)) begin
			best_cnt_q <= rd_cnt;
			best_key_q <= rd_key;
			best_idx_q <= idx_q;
		end
		if (emit) begin
			out_found_q <= (fill_q != '0);
			out_last_q  <= emit_last;
			out_key_q   <= (fill_q == '0) ? '0 : best_key_q;
			out_cnt_q   <= (fill_q == '0) ? '0 : best_cnt_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_cnt_q, out_key_q};
	assign m_tuser  = out_found_q;
	assign m_tlast  = out_last_q;

endmodule
